>>> sv/hpl_pkg.sv
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared types, widths and helpers of the Huffman path length unit.
// ----------------------------------------------------------------------------
package hpl_pkg;

   localparam int WEIGHT_FIELD_BITS  = 16;
   localparam int SUM_BITS           = 32;
   localparam int SYMBOLS_BITS       = 7;
   localparam int DEF_MAX_SYMBOLS    = 64;
   localparam int DEF_WEIGHT_BITS    = 16;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CHECK,
      ST_SCAN,
      ST_FLUSH,
      ST_ADD_PAIR,
      ST_ADD_TOTAL,
      ST_WRITE_LAST
   } hpl_state_type;

   // control of the two-smallest tracker
   typedef struct packed {
      logic clear;
      logic sample;
   } hpl_min_ctrl_type;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                   input logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
   endfunction

endpackage

>>> sv/hpl_channels.sv
// ----------------------------------------------------------------------------
// hpl channels
// Valid/ready channels for frequency words in and result words out.
// ----------------------------------------------------------------------------
interface hpl_req_if;
   import hpl_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [WEIGHT_FIELD_BITS-1:0] weight;
   logic                         last;

   modport source (output valid, output weight, output last, input ready);
   modport sink   (input valid, input weight, input last, output ready);
endinterface

interface hpl_rsp_if;
   import hpl_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SUM_BITS-1:0]     path_length;
   logic [SYMBOLS_BITS-1:0] symbols;
   logic                    overflow;

   modport source (output valid, output path_length, output symbols, output overflow,
                   input ready);
   modport sink   (input valid, input path_length, input symbols, input overflow,
                   output ready);
endinterface

>>> sv/hpl_min_unit.sv
// ----------------------------------------------------------------------------
// hpl_min_unit
// Tracks the two smallest weights and their heap slots over one scan.
// ----------------------------------------------------------------------------
module hpl_min_unit #(
   parameter int MAX_SYMBOLS = hpl_pkg::DEF_MAX_SYMBOLS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hpl_pkg::hpl_min_ctrl_type            ctrl,
   input  logic [hpl_pkg::SUM_BITS-1:0]         value,
   input  logic [$clog2(MAX_SYMBOLS)-1:0]       pos,
   output logic [hpl_pkg::SUM_BITS-1:0]         min1,
   output logic [hpl_pkg::SUM_BITS-1:0]         min2,
   output logic [$clog2(MAX_SYMBOLS)-1:0]       pos1,
   output logic [$clog2(MAX_SYMBOLS)-1:0]       pos2
);
   import hpl_pkg::*;

   localparam int ADDR_BITS = $clog2(MAX_SYMBOLS);

   logic                 have1_ff, have1_in;
   logic                 have2_ff, have2_in;
   logic [SUM_BITS-1:0]  min1_ff, min1_in;
   logic [SUM_BITS-1:0]  min2_ff, min2_in;
   logic [ADDR_BITS-1:0] pos1_ff, pos1_in;
   logic [ADDR_BITS-1:0] pos2_ff, pos2_in;

   always_comb begin
      have1_in = have1_ff;
      have2_in = have2_ff;
      min1_in  = min1_ff;
      min2_in  = min2_ff;
      pos1_in  = pos1_ff;
      pos2_in  = pos2_ff;
      if (ctrl.clear) begin
         have1_in = 1'b0;
         have2_in = 1'b0;
      end else if (ctrl.sample) begin
         if (!have1_ff) begin
            have1_in = 1'b1;
            min1_in  = value;
            pos1_in  = pos;
         end else if (value < min1_ff) begin
            // new smallest, old smallest moves down
            have2_in = 1'b1;
            min2_in  = min1_ff;
            pos2_in  = pos1_ff;
            min1_in  = value;
            pos1_in  = pos;
         end else if (!have2_ff || value < min2_ff) begin
            have2_in = 1'b1;
            min2_in  = value;
            pos2_in  = pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have1_ff <= 1'b0;
         have2_ff <= 1'b0;
      end else begin
         have1_ff <= have1_in;
         have2_ff <= have2_in;
      end
      min1_ff <= min1_in;
      min2_ff <= min2_in;
      pos1_ff <= pos1_in;
      pos2_ff <= pos2_in;
   end

   assign min1 = min1_ff;
   assign min2 = min2_ff;
   assign pos1 = pos1_ff;
   assign pos2 = pos2_ff;

   a_order : assert property (@(posedge clock) disable iff (reset)
      have2_ff |-> min1_ff <= min2_ff)
      else $error("tracked minima out of order");

   a_distinct : assert property (@(posedge clock) disable iff (reset)
      have2_ff |-> pos1_ff != pos2_ff)
      else $error("both minima taken from one slot");

   a_second_needs_first : assert property (@(posedge clock) disable iff (reset)
      have2_ff |-> have1_ff)
      else $error("second minimum without first");

endmodule

>>> sv/huffman_path_length_unit.sv
// Operation: the words are loaded at one word per cycle, then each merge scans the
// current weights, adds the pair and the running total and writes the sum back.
// Throughput: one set at a time; req is not ready from the last word until the result
// is registered. The merge rate is set by the single read port of the weight memory.
// Reset: synchronous; clears the count, total, overflow flag and result valid.
// ----------------------------------------------------------------------------
// huffman_path_length_unit
// Loads symbol frequencies and merges the two smallest weights repeatedly,
// reporting the optimal Huffman weighted path length of the set.
// ----------------------------------------------------------------------------
module huffman_path_length_unit #(
   parameter int MAX_SYMBOLS = hpl_pkg::DEF_MAX_SYMBOLS,
   parameter int WEIGHT_BITS = hpl_pkg::DEF_WEIGHT_BITS
) (
   input  logic      clock,
   input  logic      reset,
   hpl_req_if.sink   req_ch,
   hpl_rsp_if.source rsp_ch
);
   import hpl_pkg::*;

   localparam int ADDR_BITS = $clog2(MAX_SYMBOLS);
   localparam int CNT_BITS  = $clog2(MAX_SYMBOLS + 1);
   localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_SYMBOLS);
   localparam logic [SUM_BITS-1:0] WEIGHT_MASK =
      (WEIGHT_BITS >= SUM_BITS) ? '1 : SUM_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);

   hpl_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]  size_ff, size_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [SUM_BITS-1:0]  total_ff, total_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic                 dropped_ff, dropped_in;
   logic [SUM_BITS-1:0]  last_val_ff;

   logic [SUM_BITS-1:0]  heap_mem [MAX_SYMBOLS];
   logic [SUM_BITS-1:0]  rd_data_ff;
   logic [ADDR_BITS-1:0] rd_pos_ff;
   logic                 rd_vld_ff;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [SUM_BITS-1:0]  wr_data;

   logic                    rsp_valid_ff;
   logic [SUM_BITS-1:0]     rsp_path_ff;
   logic [SYMBOLS_BITS-1:0] rsp_symbols_ff;
   logic                    rsp_overflow_ff;
   logic                    rsp_load;

   hpl_min_ctrl_type     min_ctrl;
   logic [SUM_BITS-1:0]  min1, min2;
   logic [ADDR_BITS-1:0] pos1, pos2;
   logic [ADDR_BITS-1:0] last_pos;

   logic [SUM_BITS-1:0]  add_a, add_b, add_sum;
   logic                 req_ready;
   logic                 req_accept;
   logic [SUM_BITS-1:0]  in_weight;

   assign req_ready  = (state_ff == ST_LOAD);
   assign req_accept = req_ch.valid && req_ready;
   assign in_weight  = SUM_BITS'(req_ch.weight) & WEIGHT_MASK;
   assign last_pos   = ADDR_BITS'(size_ff - CNT_BITS'(1));

   // one saturating adder, used for the pair sum and then for the running total
   assign add_a   = (state_ff == ST_ADD_PAIR) ? min1 : total_ff;
   assign add_b   = (state_ff == ST_ADD_PAIR) ? min2 : sum_ff;
   assign add_sum = sat_add(add_a, add_b);

   hpl_min_unit #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_min (
      .clock (clock),
      .reset (reset),
      .ctrl  (min_ctrl),
      .value (rd_data_ff),
      .pos   (rd_pos_ff),
      .min1  (min1),
      .min2  (min2),
      .pos1  (pos1),
      .pos2  (pos2)
   );

   always_comb begin
      state_in        = state_ff;
      size_in         = size_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      total_in        = total_ff;
      sum_in          = sum_ff;
      dropped_in      = dropped_ff;
      wr_en           = 1'b0;
      wr_addr         = pos1;
      wr_data         = sum_ff;
      rsp_load        = 1'b0;
      min_ctrl.clear  = 1'b0;
      min_ctrl.sample = rd_vld_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (size_ff < MAX_CNT) begin
                  wr_en   = 1'b1;
                  wr_addr = size_ff[ADDR_BITS-1:0];
                  wr_data = in_weight;
                  size_in = size_ff + CNT_BITS'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_ch.last) begin
                  count_in = size_in;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (size_ff > CNT_BITS'(1)) begin
               min_ctrl.clear = 1'b1;
               idx_in         = '0;
               state_in       = ST_SCAN;
            end else if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load   = 1'b1;
               size_in    = '0;
               total_in   = '0;
               dropped_in = 1'b0;
               state_in   = ST_LOAD;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + CNT_BITS'(1);
            if (idx_ff == size_ff - CNT_BITS'(1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // last read word is sampled by the tracker here
            state_in = ST_ADD_PAIR;
         end
         ST_ADD_PAIR: begin
            sum_in   = add_sum;
            state_in = ST_ADD_TOTAL;
         end
         ST_ADD_TOTAL: begin
            total_in = add_sum;
            wr_en    = 1'b1;
            wr_data  = sum_ff;
            if (pos1 == last_pos) begin
               wr_addr  = pos2;
               size_in  = size_ff - CNT_BITS'(1);
               state_in = ST_CHECK;
            end else if (pos2 == last_pos) begin
               wr_addr  = pos1;
               size_in  = size_ff - CNT_BITS'(1);
               state_in = ST_CHECK;
            end else begin
               wr_addr  = pos1;
               state_in = ST_WRITE_LAST;
            end
         end
         ST_WRITE_LAST: begin
            // move the tail word into the freed slot
            wr_en    = 1'b1;
            wr_addr  = pos2;
            wr_data  = last_val_ff;
            size_in  = size_ff - CNT_BITS'(1);
            state_in = ST_CHECK;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         size_ff    <= '0;
         count_ff   <= '0;
         idx_ff     <= '0;
         total_ff   <= '0;
         dropped_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         size_ff    <= size_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         total_ff   <= total_in;
         dropped_ff <= dropped_in;
         rd_vld_ff  <= (state_ff == ST_SCAN);
      end
      sum_ff <= sum_in;
      if (rd_vld_ff && rd_pos_ff == last_pos) begin
         last_val_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[idx_ff[ADDR_BITS-1:0]];
      rd_pos_ff  <= idx_ff[ADDR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_path_ff     <= total_ff;
         rsp_symbols_ff  <= SYMBOLS_BITS'(count_ff);
         rsp_overflow_ff <= dropped_ff;
      end
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.path_length = rsp_path_ff;
   assign rsp_ch.symbols     = rsp_symbols_ff;
   assign rsp_ch.overflow    = rsp_overflow_ff;

   a_size_bound : assert property (@(posedge clock) disable iff (reset)
      size_ff <= MAX_CNT)
      else $error("weight count beyond memory depth");

   a_scan_needs_pair : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> size_ff > CNT_BITS'(1))
      else $error("merge scan with fewer than two weights");

   a_shrink : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE_LAST |=> size_ff == $past(size_ff) - CNT_BITS'(1))
      else $error("merge did not remove one weight");

   a_total_grows : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD_TOTAL |=> total_ff >= $past(total_ff))
      else $error("running total decreased");

endmodule
